### rtl/core/dcdc_sps_pkg.sv
// ----------------------------------------------------------------------------
// dcdc_sps_pkg
// Shared types, constants and helper functions for the DC-DC status poll
// sequencer: payload structs, queue entry, register indexes and fault masks.
// ----------------------------------------------------------------------------
package dcdc_sps_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned ID_W        = 29;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned TICKS_W     = 16;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned STEP_W      = 4;
    localparam int unsigned GROUP_W     = 3;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned NUM_GROUPS  = 7;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [STEP_W-1:0]  STEP_LAST     = 4'd13;
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd100;

    localparam logic [GROUP_W-1:0] GRP_STATUS  = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_FAULT_A = 3'd4;
    localparam logic [GROUP_W-1:0] GRP_FAULT_B = 3'd5;
    localparam logic [GROUP_W-1:0] GRP_MODULE  = 3'd6;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    // fault masks per word
    localparam logic [WORD_W-1:0] MASK_STATUS_W0  = 16'h0001;
    localparam logic [WORD_W-1:0] MASK_STATUS_W12 = 16'h0842;
    localparam logic [WORD_W-1:0] MASK_FAULTA_W0  = 16'h003C;
    localparam logic [WORD_W-1:0] MASK_FAULTA_W1  = 16'h6FFF;
    localparam logic [WORD_W-1:0] MASK_FAULT_BIT4 = 16'h0010;

    typedef enum logic [1:0] {
        MODE_POLL   = 2'd0,
        MODE_FRAME  = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_FRAME = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT      = 3'd0,
        CFG_ID_SYS       = 3'd1,
        CFG_ID_TEMP_A    = 3'd2,
        CFG_ID_TEMP_B    = 3'd3,
        CFG_ID_STATUS    = 3'd4,
        CFG_ID_FAULT_A   = 3'd5,
        CFG_ID_FAULT_B   = 3'd6,
        CFG_ID_MODULE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   rx_id;
        logic [DATA_W-1:0] rx_data;
    } in_item_t;

    typedef struct packed {
        logic                kind;
        logic [CODE_W-1:0]   request_code;
        logic [DATA_W-1:0]   request_payload;
        logic [GROUP_W-1:0]  reply_group;
        logic [WORD_W-1:0]   word0;
        logic [WORD_W-1:0]   word1;
        logic [WORD_W-1:0]   word2;
        logic [WORD_W-1:0]   word3;
        logic                fault;
    } out_item_t;

    typedef struct packed {
        op_t               op;
        logic [ID_W-1:0]   rx_id;
        logic [DATA_W-1:0] rx_data;
    } q_entry_t;

    function automatic logic [CODE_W-1:0] req_code(input logic [GROUP_W-1:0] grp);
        logic [CODE_W-1:0] code;
        case (grp)
            3'd0:    code = 8'hD1;
            3'd1:    code = 8'hD2;
            3'd2:    code = 8'hD3;
            3'd3:    code = 8'hDB;
            3'd4:    code = 8'hDC;
            3'd5:    code = 8'hDD;
            3'd6:    code = 8'hD5;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // bytes 7..0: 00 01 00 code 00 00 FF FF
    function automatic logic [DATA_W-1:0] req_payload(input logic [CODE_W-1:0] code);
        return {8'h00, 8'h01, 8'h00, code, 8'h00, 8'h00, 8'hFF, 8'hFF};
    endfunction

endpackage

### rtl/core/dcdc_sps_front.sv
// ----------------------------------------------------------------------------
// dcdc_sps_front
// Input side: accepts transactions, decodes the mode into an operation and
// pushes it into the queue. Unused mode codes are taken and dropped.
// ----------------------------------------------------------------------------
module dcdc_sps_front import dcdc_sps_pkg::*; (
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_ready,
    output logic     q_push,
    output q_entry_t q_push_entry
);

    logic keep;

    assign s_ready = q_ready;

    always_comb begin
        keep                 = 1'b1;
        q_push_entry.op      = OP_POLL;
        q_push_entry.rx_id   = s_data.rx_id;
        q_push_entry.rx_data = s_data.rx_data;
        case (mode_t'(s_data.mode))
            MODE_POLL:  q_push_entry.op = OP_POLL;
            MODE_FRAME: q_push_entry.op = OP_FRAME;
            MODE_TICK:  q_push_entry.op = OP_TICK;
            default:    keep = 1'b0;
        endcase
    end

    assign q_push = s_valid && q_ready && keep;

endmodule

### rtl/core/dcdc_sps_queue.sv
// ----------------------------------------------------------------------------
// dcdc_sps_queue
// Short FIFO of decoded operations between the front and back sides.
// ----------------------------------------------------------------------------
module dcdc_sps_queue import dcdc_sps_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     ready,
    input  logic     pop,
    output logic     pop_valid,
    output q_entry_t pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    q_entry_t           mem [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    assign do_push = push && ready;
    assign do_pop  = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### rtl/core/dcdc_sps_back.sv
// ----------------------------------------------------------------------------
// dcdc_sps_back
// Execution side: holds the poll step, reply latch, timeout countdown, fault
// flag and configuration registers; executes one queued operation per cycle,
// unless a result waits for m_ready, into a registered result stage.
// ----------------------------------------------------------------------------
module dcdc_sps_back import dcdc_sps_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   q_valid,
    input  q_entry_t               q_entry,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    logic [TICKS_W-1:0] timeout_reg;
    logic [ID_W-1:0]    reply_id_reg [0:NUM_GROUPS-1];

    logic [STEP_W-1:0]  step_reg, step_next;
    logic               waiting_reg, waiting_next;
    logic [TICKS_W-1:0] countdown_reg, countdown_next;
    logic               reply_seen_reg, reply_seen_next;
    logic [ID_W-1:0]    last_id_reg, last_id_next;
    logic [DATA_W-1:0]  last_data_reg, last_data_next;
    logic               fault_reg, fault_next;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [GROUP_W-1:0] grp;
    logic               step_ok;
    logic [WORD_W-1:0]  w0, w1, w2, w3;
    logic [TICKS_W-1:0] cnt_dec;
    logic               res_valid;
    out_item_t          res;

    assign cfg_ready = 1'b1;
    assign q_pop     = q_valid && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign grp     = step_reg[STEP_W-1:1];
    assign step_ok = (step_reg <= STEP_LAST);
    assign w0      = last_data_reg[15:0];
    assign w1      = last_data_reg[31:16];
    assign w2      = last_data_reg[47:32];
    assign w3      = last_data_reg[63:48];
    assign cnt_dec = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;

    always_comb begin
        step_next       = step_reg;
        waiting_next    = waiting_reg;
        countdown_next  = countdown_reg;
        reply_seen_next = reply_seen_reg;
        last_id_next    = last_id_reg;
        last_data_next  = last_data_reg;
        fault_next      = fault_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (q_pop) begin
            case (q_entry.op)
                OP_POLL: begin
                    if (!waiting_reg && step_ok) begin
                        if (!step_reg[0]) begin
                            res_valid           = 1'b1;
                            res.kind            = KIND_REQUEST;
                            res.request_code    = req_code(grp);
                            res.request_payload = req_payload(req_code(grp));
                            last_data_next      = '0;
                            step_next           = {grp, 1'b1};
                            if (reply_seen_reg) begin
                                // early reply already in hand: skip the wait
                                reply_seen_next = 1'b0;
                                waiting_next    = 1'b0;
                            end else if (timeout_reg == '0) begin
                                waiting_next = 1'b0;
                                step_next    = {grp, 1'b0};
                            end else begin
                                waiting_next   = 1'b1;
                                countdown_next = timeout_reg;
                            end
                        end else if (last_id_reg == reply_id_reg[grp]) begin
                            case (grp)
                                GRP_STATUS:  fault_next = |((w0 & MASK_STATUS_W0)
                                                          | (w1 & MASK_STATUS_W12)
                                                          | (w2 & MASK_STATUS_W12));
                                GRP_FAULT_A: fault_next = |((w0 & MASK_FAULTA_W0)
                                                          | (w1 & MASK_FAULTA_W1)
                                                          | (w2 & MASK_FAULT_BIT4)
                                                          | (w3 & MASK_FAULT_BIT4));
                                GRP_FAULT_B: fault_next = |((w0 | w1 | w2 | w3)
                                                          & MASK_FAULT_BIT4);
                                default:     fault_next = fault_reg;
                            endcase
                            step_next       = (grp == GRP_MODULE) ? '0 : {grp + 3'd1, 1'b0};
                            res_valid       = 1'b1;
                            res.kind        = KIND_REPLY;
                            res.reply_group = grp;
                            res.word0       = w0;
                            res.word1       = w1;
                            res.word2       = w2;
                            res.word3       = w3;
                            res.fault       = fault_next;
                        end
                    end
                end
                OP_FRAME: begin
                    last_id_next    = q_entry.rx_id;
                    last_data_next  = q_entry.rx_data;
                    reply_seen_next = !waiting_reg;
                    waiting_next    = 1'b0;
                end
                OP_TICK: begin
                    countdown_next = cnt_dec;
                    if (waiting_reg && cnt_dec == '0) begin
                        // timed out: back to the request step
                        waiting_next = 1'b0;
                        step_next    = step_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            for (int i = 0; i < NUM_GROUPS; i++) begin
                reply_id_reg[i] <= '0;
            end
            step_reg       <= '0;
            waiting_reg    <= 1'b0;
            countdown_reg  <= '0;
            reply_seen_reg <= 1'b0;
            last_id_reg    <= '0;
            last_data_reg  <= '0;
            fault_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_reg_t'(cfg_index) == CFG_TIMEOUT) begin
                    timeout_reg <= cfg_data[TICKS_W-1:0];
                end else begin
                    reply_id_reg[cfg_index - 3'd1] <= cfg_data[ID_W-1:0];
                end
            end
            step_reg       <= step_next;
            waiting_reg    <= waiting_next;
            countdown_reg  <= countdown_next;
            reply_seen_reg <= reply_seen_next;
            last_id_reg    <= last_id_next;
            last_data_reg  <= last_data_next;
            fault_reg      <= fault_next;
            if (q_pop && res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only when the stage is free or draining
    always_ff @(posedge aclk) begin
        if (q_pop && res_valid) begin
            m_data_reg <= res;
        end
    end

endmodule

### rtl/core/dcdc_status_poll_sequencer_unit.sv
// ----------------------------------------------------------------------------
// dcdc_status_poll_sequencer_unit
// Polls a DC-DC converter through seven CAN request and reply pairs.
// ----------------------------------------------------------------------------
// Each input transaction is a poll call, a received CAN frame or a timer
// tick. A poll at a request step yields a request frame (code and 8-byte
// payload; the link layer adds the CAN ID); a poll at a reply step whose
// latched frame ID matches the configured one yields the four decoded words
// and the updated fault flag. Frames and ticks yield no result. One
// transaction is taken per clock while the queue has room: the front side
// decodes it into a QUEUE_DEPTH-entry queue and the back side executes one
// queued operation per cycle, unless a result waits for m_ready, into a
// registered result stage, so a result passes through the queue and then
// the result register before it shows on m_valid. Input stalls only once
// a result waits for m_ready and the queue has filled.
// Configuration writes are taken every cycle and must be issued while idle.
// ----------------------------------------------------------------------------
module dcdc_status_poll_sequencer_unit import dcdc_sps_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic     q_ready;
    logic     q_push;
    q_entry_t q_push_entry;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_entry;

    dcdc_sps_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_push_entry (q_push_entry)
    );

    dcdc_sps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .ready      (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    dcdc_sps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### rtl/core/dcdc_sps_checker.sv
// ----------------------------------------------------------------------------
// dcdc_sps_port_checks
// Port-level checks on the result channel of the poll sequencer.
// ----------------------------------------------------------------------------
module dcdc_sps_port_checks import dcdc_sps_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // request frame: payload follows the code, reply fields clear
    a_request_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_REQUEST |->
            m_data.request_payload == req_payload(m_data.request_code) &&
            m_data.reply_group == '0 && m_data.word0 == '0 && m_data.word1 == '0 &&
            m_data.word2 == '0 && m_data.word3 == '0 && !m_data.fault)
        else $error("malformed request result");

    // decoded reply: request fields clear, group in range
    a_reply_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_REPLY |->
            m_data.request_code == '0 && m_data.request_payload == '0 &&
            m_data.reply_group != GROUP_W'(NUM_GROUPS))
        else $error("malformed reply result");

endmodule

bind dcdc_status_poll_sequencer_unit dcdc_sps_port_checks u_port_checks (.*);
